FILE: rtl/core/ltc_pkg.sv
`timescale 1ns / 1ps

package ltc_pkg;

    localparam int unsigned CharW  = 8;
    localparam int unsigned ClassW = 4;

    typedef logic [CharW-1:0] t_char;

    typedef enum logic [5:0] {
        S_START, S_SIGN, S_INT, S_FRAC,
        S_EE, S_EES, S_EED, S_DE, S_DES, S_DED,
        S_U, S_L, S_LA, S_LAT, S_LO, S_LON,
        S_R, S_RA, S_RAD, S_D, S_DEX, S_DEG,
        S_M, S_MI, S_MIN, S_S, S_SE, S_SEC,
        S_T, S_TR, S_TRU, S_TRUE, S_F, S_FA, S_FAL, S_FALS, S_FALSE,
        S_DEAD
    } t_scan_state;

    typedef enum logic [ClassW-1:0] {
        C_STRING    = 4'd0,
        C_DECIMAL   = 4'd1,
        C_INTEGER   = 4'd2,
        C_BOOLEAN   = 4'd3,
        C_LATITUDE  = 4'd4,
        C_LONGITUDE = 4'd5,
        C_RADIAN    = 4'd6,
        C_DEGREE    = 4'd7,
        C_ARCMIN    = 4'd8,
        C_ARCSEC    = 4'd9
    } t_token_class;

    // Transition result handed from the automaton to the result stage
    typedef struct packed {
        t_scan_state  nxt;
        t_token_class cls;
    } t_step;

    function automatic logic is_digit(input t_char c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_sign(input t_char c);
        return (c == "+") || (c == "-");
    endfunction

endpackage

FILE: rtl/core/ltc_next.sv
`timescale 1ns / 1ps

module ltc_next import ltc_pkg::*; (
    input  t_scan_state i_state,
    input  t_char       i_char,
    output t_step       o_step
);

    t_scan_state nxt;
    t_char       c;

    assign c = i_char;

    always_comb begin
        nxt = S_DEAD;
        case (i_state)
            S_START: begin
                if (is_sign(c))                nxt = S_SIGN;
                else if (is_digit(c))          nxt = S_INT;
                else if (c == "T" || c == "t") nxt = S_T;
                else if (c == "F" || c == "f") nxt = S_F;
            end
            S_SIGN: if (is_digit(c)) nxt = S_INT;
            S_INT: begin
                if (is_digit(c))   nxt = S_INT;
                else if (c == ".") nxt = S_FRAC;
            end
            S_FRAC: begin
                if (is_digit(c))               nxt = S_FRAC;
                else if (c == "E" || c == "e") nxt = S_EE;
                else if (c == "D")             nxt = S_DE;
                else if (c == "_")             nxt = S_U;
            end
            S_EE: begin
                if (is_sign(c))       nxt = S_EES;
                else if (is_digit(c)) nxt = S_EED;
            end
            S_EES: if (is_digit(c)) nxt = S_EED;
            S_EED: begin
                if (is_digit(c))   nxt = S_EED;
                else if (c == "_") nxt = S_U;
            end
            // D exponent takes no suffix
            S_DE: begin
                if (is_sign(c))       nxt = S_DES;
                else if (is_digit(c)) nxt = S_DED;
            end
            S_DES, S_DED: if (is_digit(c)) nxt = S_DED;
            S_U: begin
                if (c == "l")      nxt = S_L;
                else if (c == "r") nxt = S_R;
                else if (c == "d") nxt = S_D;
                else if (c == "m") nxt = S_M;
                else if (c == "s") nxt = S_S;
            end
            S_L: begin
                if (c == "a")      nxt = S_LA;
                else if (c == "o") nxt = S_LO;
            end
            S_LA:   if (c == "t") nxt = S_LAT;
            S_LO:   if (c == "n") nxt = S_LON;
            S_R:    if (c == "a") nxt = S_RA;
            S_RA:   if (c == "d") nxt = S_RAD;
            S_D:    if (c == "e") nxt = S_DEX;
            S_DEX:  if (c == "g") nxt = S_DEG;
            S_M:    if (c == "i") nxt = S_MI;
            S_MI:   if (c == "n") nxt = S_MIN;
            S_S:    if (c == "e") nxt = S_SE;
            S_SE:   if (c == "c") nxt = S_SEC;
            S_T:    if (c == "r") nxt = S_TR;
            S_TR:   if (c == "u") nxt = S_TRU;
            S_TRU:  if (c == "e") nxt = S_TRUE;
            S_F:    if (c == "a") nxt = S_FA;
            S_FA:   if (c == "l") nxt = S_FAL;
            S_FAL:  if (c == "s") nxt = S_FALS;
            S_FALS: if (c == "e") nxt = S_FALSE;
            default: nxt = S_DEAD;
        endcase
    end

    always_comb begin
        o_step.nxt = nxt;
        case (nxt)
            S_FRAC, S_EED, S_DED: o_step.cls = C_DECIMAL;
            S_INT:                o_step.cls = C_INTEGER;
            S_TRUE, S_FALSE:      o_step.cls = C_BOOLEAN;
            S_LAT:                o_step.cls = C_LATITUDE;
            S_LON:                o_step.cls = C_LONGITUDE;
            S_RAD:                o_step.cls = C_RADIAN;
            S_DEG:                o_step.cls = C_DEGREE;
            S_MIN:                o_step.cls = C_ARCMIN;
            S_SEC:                o_step.cls = C_ARCSEC;
            default:              o_step.cls = C_STRING;
        endcase
    end

endmodule

FILE: rtl/core/ltc_result_reg.sv
`timescale 1ns / 1ps

module ltc_result_reg import ltc_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_load,
    input  t_token_class i_cls,
    output logic         o_free,
    output logic         o_valid,
    input  logic         i_ready,
    output t_token_class o_cls
);

    logic         r_valid;
    t_token_class r_cls;

    // slot can take a new result if empty or being drained this cycle
    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_cls   = r_cls;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_cls <= i_cls;
        end
    end

endmodule

FILE: rtl/core/literal_token_classifier.sv
`timescale 1ns / 1ps

// Numeric literal token classifier.
// Input channel: i_in_valid / o_in_ready carry one token byte (i_char_code)
// per transfer, i_last_char marking the final byte of the token.
// Output channel: o_out_valid / i_out_ready carry one class code
// (o_token_class) per token, issued for the transfer with i_last_char set:
// 0 string, 1 decimal, 2 integer, 3 boolean, 4 lat, 5 lon, 6 rad,
// 7 deg, 8 arcmin, 9 arcsec.
// Throughput: one byte per cycle except while a final byte is stalled.
// The byte register feeds one automaton transition per cycle; the class
// lands in the result register. A final byte is first held in the
// byte register; its class loads into the result register once free.
// Reset: the automaton returns to the token start state and both
// registers are emptied.
// Stall: while the result register holds an untaken class, bytes within
// a token keep flowing; a further final byte waits in the byte register
// and o_in_ready drops until the result is taken.

module literal_token_classifier import ltc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [CharW-1:0]  i_char_code,
    input  logic              i_last_char,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [ClassW-1:0] o_token_class
);

    logic        r_in_valid;
    t_char       r_in_char;
    logic        r_in_last;
    t_scan_state r_state;
    t_scan_state n_state;

    t_step        step;
    t_token_class res_cls;
    logic         res_free;
    logic         advance;
    logic         load;

    ltc_next u_next (
        .i_state (r_state),
        .i_char  (r_in_char),
        .o_step  (step)
    );

    assign advance    = r_in_valid && (!r_in_last || res_free);
    assign load       = advance && r_in_last;
    assign o_in_ready = !r_in_valid || advance;

    always_comb begin
        n_state = r_state;
        if (advance) begin
            n_state = r_in_last ? S_START : step.nxt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_state    <= S_START;
        end else begin
            r_state <= n_state;
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_char <= i_char_code;
            r_in_last <= i_last_char;
        end
    end

    ltc_result_reg u_result (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_cls   (step.cls),
        .o_free  (res_free),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_cls   (res_cls)
    );

    assign o_token_class = res_cls;

endmodule
